[src/tmcd_pkg.sv]
// ----------------------------------------------------------------------------
// tmcd_pkg
// Shared constants, input codes and a helper function for the trajectory
// mean color difference block.
// ----------------------------------------------------------------------------
package tmcd_pkg;

  localparam int POINT_COUNT     = 4096;
  localparam int TRACK_COUNT     = 1024;
  localparam int CHANNEL_COUNT   = 3;
  localparam int FRAME_BITS      = 16;
  localparam int POINT_ADDR_BITS = $clog2(POINT_COUNT);
  localparam int TRACK_ADDR_BITS = $clog2(TRACK_COUNT);
  localparam int VALUE_BITS      = 24;
  localparam int LEN_BITS        = FRAME_BITS + 1;
  localparam int SUM_BITS        = 26;
  localparam int AFF_BITS        = 17;
  localparam int DEN_BITS        = 27;
  localparam int CNT_BITS        = 5;
  localparam int FULL_SCALE      = 765;

  localparam logic [1:0] KIND_WRITE_POINT = 2'd0;
  localparam logic [1:0] KIND_WRITE_TRACK = 2'd1;
  localparam logic [1:0] KIND_QUERY_PAIR  = 2'd2;

  // sum of absolute differences over the used channels
  function automatic logic [9:0] channel_abs_sum(input logic [VALUE_BITS-1:0] a,
                                                 input logic [VALUE_BITS-1:0] b);
    logic [9:0] acc;
    logic [7:0] ca;
    logic [7:0] cb;
    acc = '0;
    for (int k = 0; k < CHANNEL_COUNT; k++) begin
      ca = a[8*k +: 8];
      cb = b[8*k +: 8];
      acc = acc + ((ca > cb) ? 10'(ca - cb) : 10'(cb - ca));
    end
    return acc;
  endfunction

endpackage

[src/tmcd_ram.sv]
// ----------------------------------------------------------------------------
// tmcd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tmcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/trajectory_mean_color_difference.sv]
// ----------------------------------------------------------------------------
// trajectory_mean_color_difference
// Point and track record store with a track pair query that sums absolute
// channel differences over the common frame span and gives the mean.
// ----------------------------------------------------------------------------
// Point and track writes never raise busy. A pair query raises busy until it
// ends with a one-cycle out_valid strobe; a query with no overlap ends at the
// span check without a walk. The walk reads two point values per frame
// through the single read port of the point value memory, and the mean comes
// from a one-bit-per-cycle divider. The receiver cannot stall: each result is
// flagged for exactly the one cycle out_valid is high.
module trajectory_mean_color_difference (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_kind,
  input  logic [11:0]                           in_point_index,
  input  logic [15:0]                           in_frame_number,
  input  logic [7:0]                            in_value_c0,
  input  logic [7:0]                            in_value_c1,
  input  logic [7:0]                            in_value_c2,
  input  logic [9:0]                            in_track_index,
  input  logic [11:0]                           in_track_first_point,
  input  logic [11:0]                           in_track_last_point,
  input  logic [9:0]                            in_other_track,
  output logic                                  out_valid,
  output logic                                  out_no_overlap,
  output logic [16:0]                           out_overlap_length,
  output logic [25:0]                           out_difference_sum,
  output logic [16:0]                           out_affinity
);

  typedef enum logic [3:0] {
    S_IDLE, S_TRK_A, S_TRK_B, S_PT_SA, S_PT_SB, S_PT_LA, S_PT_LB,
    S_SPAN, S_WALK_A, S_WALK_B, S_ACC, S_MUL, S_DIV
  } state_t;

  localparam int PB = tmcd_pkg::POINT_ADDR_BITS;
  localparam int TB = tmcd_pkg::TRACK_ADDR_BITS;
  localparam int FB = tmcd_pkg::FRAME_BITS;

  state_t state_r;

  logic [TB-1:0] ta_r, tb_r;
  logic [PB-1:0] sa_r, sb_r, la_r, lb_r;
  logic [FB-1:0] fa_r, fb_r, ea_r;
  logic [FB-1:0] f_r, ce_r;
  logic [PB-1:0] pa_r, pb_r;
  logic [tmcd_pkg::VALUE_BITS-1:0] va_r;
  logic [tmcd_pkg::LEN_BITS-1:0]   len_r;
  logic [tmcd_pkg::SUM_BITS-1:0]   sum_r;
  logic [tmcd_pkg::DEN_BITS-1:0]   den_r;
  logic [tmcd_pkg::DEN_BITS-1:0]   rem_r;
  logic [tmcd_pkg::AFF_BITS-1:0]   quo_r;
  logic [tmcd_pkg::CNT_BITS-1:0]   cnt_r;

  logic                            out_valid_r;
  logic                            out_no_overlap_r;
  logic [tmcd_pkg::LEN_BITS-1:0]   out_len_r;
  logic [tmcd_pkg::SUM_BITS-1:0]   out_sum_r;
  logic [tmcd_pkg::AFF_BITS-1:0]   out_aff_r;

  logic accept;
  logic pt_we, trk_we;
  logic [TB-1:0] trk_raddr;
  logic [PB-1:0] frm_raddr, val_raddr;
  logic [PB-1:0] first_rd, last_rd;
  logic [FB-1:0] frm_rd;
  logic [tmcd_pkg::VALUE_BITS-1:0] val_rd;
  logic [tmcd_pkg::VALUE_BITS-1:0] val_wdata;

  logic [FB-1:0] cs, ce;
  logic [tmcd_pkg::DEN_BITS:0] trial, diff;
  logic qbit;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign pt_we  = accept && (in_kind == tmcd_pkg::KIND_WRITE_POINT);
  assign trk_we = accept && (in_kind == tmcd_pkg::KIND_WRITE_TRACK);
  assign val_wdata = {in_value_c2, in_value_c1, in_value_c0};

  assign trk_raddr = (state_r == S_TRK_A) ? ta_r : tb_r;

  always_comb begin
    case (state_r)
      S_PT_SA: frm_raddr = sa_r;
      S_PT_SB: frm_raddr = sb_r;
      S_PT_LA: frm_raddr = la_r;
      default: frm_raddr = lb_r;
    endcase
  end

  always_comb begin
    case (state_r)
      S_WALK_B: val_raddr = pb_r;
      S_ACC:    val_raddr = pa_r + 1'b1;
      default:  val_raddr = pa_r;
    endcase
  end

  tmcd_ram #(.WIDTH(FB), .DEPTH(tmcd_pkg::POINT_COUNT)) u_frame_ram (
    .clk(clk), .we(pt_we), .waddr(in_point_index), .wdata(in_frame_number[FB-1:0]),
    .raddr(frm_raddr), .rdata(frm_rd)
  );

  tmcd_ram #(.WIDTH(tmcd_pkg::VALUE_BITS), .DEPTH(tmcd_pkg::POINT_COUNT)) u_value_ram (
    .clk(clk), .we(pt_we), .waddr(in_point_index), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rd)
  );

  tmcd_ram #(.WIDTH(PB), .DEPTH(tmcd_pkg::TRACK_COUNT)) u_first_ram (
    .clk(clk), .we(trk_we), .waddr(in_track_index), .wdata(in_track_first_point),
    .raddr(trk_raddr), .rdata(first_rd)
  );

  tmcd_ram #(.WIDTH(PB), .DEPTH(tmcd_pkg::TRACK_COUNT)) u_last_ram (
    .clk(clk), .we(trk_we), .waddr(in_track_index), .wdata(in_track_last_point),
    .raddr(trk_raddr), .rdata(last_rd)
  );

  // common span, end frame of the second track arrives in S_SPAN
  assign cs = (fa_r > fb_r) ? fa_r : fb_r;
  assign ce = (ea_r < frm_rd) ? ea_r : frm_rd;

  // restoring divider step
  assign trial = {rem_r, quo_r[tmcd_pkg::AFF_BITS-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_kind == tmcd_pkg::KIND_QUERY_PAIR)) begin
            ta_r    <= in_track_index;
            tb_r    <= in_other_track;
            state_r <= S_TRK_A;
          end
        end
        S_TRK_A: begin
          state_r <= S_TRK_B;
        end
        S_TRK_B: begin
          sa_r    <= first_rd;
          la_r    <= last_rd;
          state_r <= S_PT_SA;
        end
        S_PT_SA: begin
          sb_r    <= first_rd;
          lb_r    <= last_rd;
          state_r <= S_PT_SB;
        end
        S_PT_SB: begin
          fa_r    <= frm_rd;
          state_r <= S_PT_LA;
        end
        S_PT_LA: begin
          fb_r    <= frm_rd;
          state_r <= S_PT_LB;
        end
        S_PT_LB: begin
          ea_r    <= frm_rd;
          state_r <= S_SPAN;
        end
        S_SPAN: begin
          if (ce < cs) begin
            out_valid_r      <= 1'b1;
            out_no_overlap_r <= 1'b1;
            out_len_r        <= '0;
            out_sum_r        <= '0;
            out_aff_r        <= '0;
            state_r          <= S_IDLE;
          end else begin
            f_r     <= cs;
            ce_r    <= ce;
            len_r   <= {1'b0, ce} - {1'b0, cs} + 1'b1;
            pa_r    <= sa_r + PB'(cs - fa_r);
            pb_r    <= sb_r + PB'(cs - fb_r);
            sum_r   <= '0;
            state_r <= S_WALK_A;
          end
        end
        S_WALK_A: begin
          state_r <= S_WALK_B;
        end
        S_WALK_B: begin
          va_r    <= val_rd;
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r <= sum_r + tmcd_pkg::SUM_BITS'(tmcd_pkg::channel_abs_sum(va_r, val_rd));
          if (f_r == ce_r) begin
            state_r <= S_MUL;
          end else begin
            f_r     <= f_r + 1'b1;
            pa_r    <= pa_r + 1'b1;
            pb_r    <= pb_r + 1'b1;
            state_r <= S_WALK_B;
          end
        end
        S_MUL: begin
          den_r   <= tmcd_pkg::DEN_BITS'(len_r) * tmcd_pkg::DEN_BITS'(tmcd_pkg::FULL_SCALE);
          rem_r   <= tmcd_pkg::DEN_BITS'(sum_r[tmcd_pkg::SUM_BITS-1:1]);
          quo_r   <= {sum_r[0], 16'd0};
          cnt_r   <= tmcd_pkg::CNT_BITS'(tmcd_pkg::AFF_BITS - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= qbit ? diff[tmcd_pkg::DEN_BITS-1:0] : trial[tmcd_pkg::DEN_BITS-1:0];
          quo_r <= {quo_r[tmcd_pkg::AFF_BITS-2:0], qbit};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            out_valid_r      <= 1'b1;
            out_no_overlap_r <= 1'b0;
            out_len_r        <= len_r;
            out_sum_r        <= sum_r;
            out_aff_r        <= {quo_r[tmcd_pkg::AFF_BITS-2:0], qbit};
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_no_overlap     = out_no_overlap_r;
  assign out_overlap_length = out_len_r;
  assign out_difference_sum = out_sum_r;
  assign out_affinity       = out_aff_r;

  // empty span result carries all zero fields
  a_no_overlap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_overlap |->
      out_overlap_length == '0 && out_difference_sum == '0 && out_affinity == '0)
    else $error("no-overlap result with nonzero fields");

  // a real overlap has at least one frame
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_no_overlap |-> out_overlap_length != '0)
    else $error("overlap result with zero length");

  // mean never exceeds full scale
  a_aff_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_affinity <= 17'h10000)
    else $error("affinity above one");

  // record writes complete in the transfer cycle
  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_kind != tmcd_pkg::KIND_QUERY_PAIR |=> !busy && !out_valid)
    else $error("record write raised busy or a result");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb - trajectory mean color difference testbench
// Writes point and track records and issues track pair queries through the
// start/busy command port. A scoreboard class keeps its own copy of the point
// and track memories, works out each query's overlap length, difference sum
// and affinity, and checks every out_valid strobe against the oldest pending
// query. Queries go out only when every entry they read has been written.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [11:0] point_index;
    logic [15:0] frame_number;
    logic [7:0]  value_c0;
    logic [7:0]  value_c1;
    logic [7:0]  value_c2;
    logic [9:0]  track_index;
    logic [11:0] track_first_point;
    logic [11:0] track_last_point;
    logic [9:0]  other_track;
  } track_cmd_t;

  typedef struct {
    logic        no_overlap;
    logic [16:0] overlap_length;
    logic [25:0] difference_sum;
    logic [16:0] affinity;
  } pair_result_t;

  class affinity_book;
    logic [15:0] frame_mem [tmcd_pkg::POINT_COUNT];
    logic [23:0] value_mem [tmcd_pkg::POINT_COUNT];
    logic [11:0] first_mem [tmcd_pkg::TRACK_COUNT];
    logic [11:0] last_mem [tmcd_pkg::TRACK_COUNT];
    bit          point_set [tmcd_pkg::POINT_COUNT];
    bit          track_set [tmcd_pkg::TRACK_COUNT];
    pair_result_t affinity_due [$];
    int errors;
    int writes;
    int queries;
    int empties;
    int longest;

    function new();
      errors  = 0;
      writes  = 0;
      queries = 0;
      empties = 0;
      longest = 0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    function void span_of(input logic [9:0] ta, input logic [9:0] tb,
                          output int sa, output int sb, output int fa, output int fb,
                          output int cs, output int ce);
      int ea;
      int eb;
      sa = int'(first_mem[ta]);
      sb = int'(first_mem[tb]);
      fa = int'(frame_mem[sa]);
      fb = int'(frame_mem[sb]);
      ea = int'(frame_mem[last_mem[ta]]);
      eb = int'(frame_mem[last_mem[tb]]);
      cs = (fa > fb) ? fa : fb;
      ce = (ea < eb) ? ea : eb;
    endfunction

    // true when the query only touches written entries and walks at most maxlen frames
    function bit walk_ok(input logic [9:0] ta, input logic [9:0] tb, input int maxlen);
      int sa, sb, fa, fb, cs, ce;
      if (!track_set[ta] || !track_set[tb]) return 0;
      if (!point_set[first_mem[ta]] || !point_set[last_mem[ta]]) return 0;
      if (!point_set[first_mem[tb]] || !point_set[last_mem[tb]]) return 0;
      span_of(ta, tb, sa, sb, fa, fb, cs, ce);
      if (ce < cs) return 1;
      if (ce - cs + 1 > maxlen) return 0;
      for (int f = cs; f <= ce; f++) begin
        if (!point_set[12'(sa + f - fa)] || !point_set[12'(sb + f - fb)]) return 0;
      end
      return 1;
    endfunction

    function pair_result_t pair_affinity(input logic [9:0] ta, input logic [9:0] tb);
      int sa, sb, fa, fb, cs, ce;
      longint total;
      longint len;
      logic [23:0] va;
      logic [23:0] vb;
      pair_result_t r;
      span_of(ta, tb, sa, sb, fa, fb, cs, ce);
      if (ce < cs) begin
        r.no_overlap     = 1'b1;
        r.overlap_length = '0;
        r.difference_sum = '0;
        r.affinity       = '0;
        return r;
      end
      len   = longint'(ce - cs + 1);
      total = 0;
      for (int f = cs; f <= ce; f++) begin
        va = value_mem[12'(sa + f - fa)];
        vb = value_mem[12'(sb + f - fb)];
        for (int k = 0; k < tmcd_pkg::CHANNEL_COUNT; k++) begin
          if (va[8*k +: 8] > vb[8*k +: 8])
            total += longint'(int'(va[8*k +: 8]) - int'(vb[8*k +: 8]));
          else
            total += longint'(int'(vb[8*k +: 8]) - int'(va[8*k +: 8]));
        end
      end
      r.no_overlap     = 1'b0;
      r.overlap_length = 17'(len);
      r.difference_sum = 26'(total);
      r.affinity       = 17'((total << 16) / (len * longint'(tmcd_pkg::FULL_SCALE)));
      return r;
    endfunction

    function void note_command(input track_cmd_t c);
      pair_result_t r;
      case (c.kind)
        tmcd_pkg::KIND_WRITE_POINT: begin
          frame_mem[c.point_index] = c.frame_number;
          value_mem[c.point_index] = {c.value_c2, c.value_c1, c.value_c0};
          point_set[c.point_index] = 1'b1;
          writes++;
        end
        tmcd_pkg::KIND_WRITE_TRACK: begin
          first_mem[c.track_index] = c.track_first_point;
          last_mem[c.track_index]  = c.track_last_point;
          track_set[c.track_index] = 1'b1;
          writes++;
        end
        tmcd_pkg::KIND_QUERY_PAIR: begin
          r = pair_affinity(c.track_index, c.other_track);
          affinity_due.push_back(r);
          queries++;
          if (r.no_overlap) empties++;
          if (int'(r.overlap_length) > longest) longest = int'(r.overlap_length);
        end
        default: ;
      endcase
    endfunction

    task check_result(input logic no_ov, input logic [16:0] len,
                      input logic [25:0] sum, input logic [16:0] aff);
      pair_result_t e;
      if (affinity_due.size() == 0) begin
        report("result with no query pending", 32'(sum), 0);
        return;
      end
      e = affinity_due.pop_front();
      if (no_ov !== e.no_overlap) report("no_overlap", 32'(no_ov), 32'(e.no_overlap));
      if (len !== e.overlap_length)
        report("overlap_length", 32'(len), 32'(e.overlap_length));
      if (sum !== e.difference_sum)
        report("difference_sum", 32'(sum), 32'(e.difference_sum));
      if (aff !== e.affinity) report("affinity", 32'(aff), 32'(e.affinity));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [11:0] in_point_index = '0;
  logic [15:0] in_frame_number = '0;
  logic [7:0]  in_value_c0 = '0;
  logic [7:0]  in_value_c1 = '0;
  logic [7:0]  in_value_c2 = '0;
  logic [9:0]  in_track_index = '0;
  logic [11:0] in_track_first_point = '0;
  logic [11:0] in_track_last_point = '0;
  logic [9:0]  in_other_track = '0;
  logic        out_valid;
  logic        out_no_overlap;
  logic [16:0] out_overlap_length;
  logic [25:0] out_difference_sum;
  logic [16:0] out_affinity;

  affinity_book book = new();
  int  sent = 0;
  bit  burst = 0;
  int  built [$];

  always #5 clk = ~clk;

  trajectory_mean_color_difference u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_point_index       (in_point_index),
    .in_frame_number      (in_frame_number),
    .in_value_c0          (in_value_c0),
    .in_value_c1          (in_value_c1),
    .in_value_c2          (in_value_c2),
    .in_track_index       (in_track_index),
    .in_track_first_point (in_track_first_point),
    .in_track_last_point  (in_track_last_point),
    .in_other_track       (in_other_track),
    .out_valid            (out_valid),
    .out_no_overlap       (out_no_overlap),
    .out_overlap_length   (out_overlap_length),
    .out_difference_sum   (out_difference_sum),
    .out_affinity         (out_affinity)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      book.check_result(out_no_overlap, out_overlap_length, out_difference_sum, out_affinity);
  end

  function automatic track_cmd_t rand_cmd();
    track_cmd_t c;
    c.kind              = 2'($urandom);
    c.point_index       = 12'($urandom);
    c.frame_number      = 16'($urandom);
    c.value_c0          = 8'($urandom);
    c.value_c1          = 8'($urandom);
    c.value_c2          = 8'($urandom);
    c.track_index       = 10'($urandom);
    c.track_first_point = 12'($urandom);
    c.track_last_point  = 12'($urandom);
    c.other_track       = 10'($urandom);
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // holds the command until the transfer happens
  task automatic send(input track_cmd_t c);
    in_kind              <= c.kind;
    in_point_index       <= c.point_index;
    in_frame_number      <= c.frame_number;
    in_value_c0          <= c.value_c0;
    in_value_c1          <= c.value_c1;
    in_value_c2          <= c.value_c2;
    in_track_index       <= c.track_index;
    in_track_first_point <= c.track_first_point;
    in_track_last_point  <= c.track_last_point;
    in_other_track       <= c.other_track;
    start                <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_command(c);
    if (c.kind != KIND_UNUSED) sent++;
  endtask

  task automatic issue(input track_cmd_t c);
    int gap;
    send(c);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (book.affinity_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_track(input int slot, input int first, input int last);
    track_cmd_t c;
    c                   = rand_cmd();
    c.kind              = tmcd_pkg::KIND_WRITE_TRACK;
    c.track_index       = 10'(slot);
    c.track_first_point = 12'(first);
    c.track_last_point  = 12'(last);
    issue(c);
  endtask

  task automatic query(input int ta, input int tb);
    track_cmd_t c;
    c             = rand_cmd();
    c.kind        = tmcd_pkg::KIND_QUERY_PAIR;
    c.track_index = 10'(ta);
    c.other_track = 10'(tb);
    issue(c);
  endtask

  // consecutive points, one per frame, then the track record; style 1 all 255, 2 all 0
  task automatic build_track(input int slot, input int p0, input int f0, input int n,
                             input int style);
    track_cmd_t c;
    logic [23:0] rgb;
    for (int i = 0; i < n; i++) begin
      rgb            = (style == 1) ? 24'hFFFFFF : (style == 2) ? 24'h0 : 24'($urandom);
      c              = rand_cmd();
      c.kind         = tmcd_pkg::KIND_WRITE_POINT;
      c.point_index  = 12'(p0 + i);
      c.frame_number = 16'(f0 + i);
      c.value_c0     = rgb[7:0];
      c.value_c1     = rgb[15:8];
      c.value_c2     = rgb[23:16];
      issue(c);
    end
    write_track(slot, p0 % 4096, (p0 + n - 1) % 4096);
    built.push_back(slot);
  endtask

  initial begin
    track_cmd_t c;
    int scene, r, n, f0, ta, tb, depth, waited;
    bit drained;
    drained = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // unused kind with all fields low and all high
    c = '{default: '0};
    c.kind = KIND_UNUSED;
    issue(c);
    c = '{default: '1};
    issue(c);
    // full scale tracks at the top frames, one wrapping the point index
    build_track(1023, 4094, 65532, 4, 1);
    build_track(0, 100, 65532, 4, 2);
    query(1023, 0);
    query(0, 0);
    // disjoint spans
    build_track(5, 200, 0, 2, 0);
    query(5, 0);
    query(0, 5);
    // single frame overlap
    write_track(6, 4095, 4095);
    query(6, 0);
    drain();

    scene = $urandom_range(0, 65535);
    while (sent < 400) begin
      if ($urandom_range(0, 59) == 0) begin
        r = $urandom_range(0, 3);
        scene = (r == 0) ? 0 : (r == 1) ? 65535 - $urandom_range(0, 30)
                                         : $urandom_range(0, 65535);
      end
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (sent >= 200 && !drained) begin
        drain();
        drained = 1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        r  = $urandom_range(0, 99);
        n  = (r < 70) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 40)
                                                         : $urandom_range(41, 250);
        f0 = scene + $urandom_range(0, 24);
        if (f0 + n - 1 > 65535) f0 = 65536 - n;
        r  = $urandom_range(0, 9);
        build_track($urandom_range(0, 1023), $urandom_range(0, 4095), f0, n,
                    (r == 0) ? 1 : (r == 1) ? 2 : 0);
      end else if (r < 85) begin
        if (built.size() != 0) begin
          depth = (built.size() < 8) ? built.size() - 1 : 7;
          for (int t = 0; t < 8; t++) begin
            ta = built[built.size() - 1 - $urandom_range(0, depth)];
            tb = ($urandom_range(0, 9) == 0) ? ta
                 : built[built.size() - 1 - $urandom_range(0, depth)];
            if (book.walk_ok(10'(ta), 10'(tb), 300)) begin
              query(ta, tb);
              break;
            end
          end
        end
      end else if (r < 93) begin
        c = rand_cmd();
        c.kind = tmcd_pkg::KIND_WRITE_POINT;
        issue(c);
      end else if (r < 97) begin
        c = rand_cmd();
        c.kind = tmcd_pkg::KIND_WRITE_TRACK;
        issue(c);
      end else begin
        c = rand_cmd();
        c.kind = KIND_UNUSED;
        issue(c);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (book.affinity_due.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (64) @(posedge clk);
    if (book.affinity_due.size() != 0)
      book.report("queries left without a result", 0, book.affinity_due.size());
    $display("covered %0d record writes and %0d pair queries, %0d of them with no common frame",
             book.writes, book.queries, book.empties);
    $display("longest common span %0d frames, with wrapped, full scale and single frame tracks",
             book.longest);
    if (book.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
